>>> hdl/ide_pkg.sv
// shared constants, types and slot arithmetic for the indexed deque engine
package ide_pkg;

    // store geometry
    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // fixed field widths of the streams
    localparam int REQ_W    = 3;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

    // packed stream widths, rounded up to whole bytes
    localparam int S_DATA_BITS = WORD_BITS + POS_W;
    localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = STATUS_W + CNT_W + 2 * WORD_BITS;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_INSERT     = 3'd4,
        REQ_ERASE      = 3'd5
    } req_t;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_POS   = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef logic [ADDR_W-1:0]    slot_t;
    typedef logic [WORD_BITS-1:0] word_t;

    // access to the word store from the sequencer
    typedef struct packed {
        logic  wr_en;
        slot_t wr_addr;
        word_t wr_data;
        logic  rd_en;
        slot_t rd_addr;
    } store_req_t;

    // circular slot addition, both operands below DEPTH
    function automatic slot_t slot_add(input slot_t a, input slot_t b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (ADDR_W+1)'(DEPTH)) begin
            s = s - (ADDR_W+1)'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    function automatic slot_t slot_inc(input slot_t a);
        return (a == ADDR_W'(DEPTH - 1)) ? '0 : a + ADDR_W'(1);
    endfunction

    function automatic slot_t slot_dec(input slot_t a);
        return (a == '0) ? ADDR_W'(DEPTH - 1) : a - ADDR_W'(1);
    endfunction

endpackage

>>> hdl/ide_store.sv
// word store of the deque: one write port, one registered read port
module ide_store (
    input  logic               aclk,
    input  ide_pkg::store_req_t req,
    output ide_pkg::word_t     rd_data
);
    import ide_pkg::*;

    word_t mem [DEPTH];
    word_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/indexed_deque_engine.sv
// top level of the indexed deque engine: request sequencer and result register
//
// Bounded deque of signed words held in a circular store with indexed insert
// and erase. Each request on the s_ channel (s_tuser: request code, s_tdata:
// word and position) gives exactly one result on the m_ channel: status,
// word count, front word and back word (zero when empty).
// Insert and erase move the words on the side nearer an end by one slot,
// one word at a time through the single store port: a read then a write
// per word. From acceptance a request steps through decide, the moves, the
// write of the new word (insert or push only), the front and back reads and
// the wait for the result register. At most DEPTH/2 - 1 words are moved;
// pushes and pops move no word, nor does a rejected or ignored request.
// s_tready is high only while the sequencer waits for a request, so a new
// request can be accepted in the cycle after the previous result is loaded.
// The result register lets the next request start while a result still waits;
// a finished request holds in its last step while the receiver stalls.
// Reset (aresetn low, synchronous) empties the deque and drops any result;
// store contents are not cleared.
module indexed_deque_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ide_pkg::REQ_W-1:0]     s_tuser,  // req_type
    input  logic [ide_pkg::S_DATA_W-1:0]  s_tdata,  // data, position, zero pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ide_pkg::M_DATA_W-1:0]  m_tdata   // status, count, front_word,
                                                    // back_word, zero pad
);
    import ide_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECIDE   = 8'b0000_0010,
        S_SHIFT_RD = 8'b0000_0100,
        S_SHIFT_WR = 8'b0000_1000,
        S_PUT      = 8'b0001_0000,
        S_FETCH_F  = 8'b0010_0000,
        S_FETCH_B  = 8'b0100_0000,
        S_CAP_B    = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;
    req_t                   req_reg;
    word_t                  data_reg;
    logic [POS_W-1:0]       pos_reg;
    slot_t                  head_reg, head_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    status_t                status_reg, status_next;
    slot_t                  dst_reg, dst_next;
    logic                   up_reg, up_next;
    logic [CNT_W-1:0]       steps_reg, steps_next;
    slot_t                  put_reg, put_next;
    logic                   ins_reg, ins_next;
    word_t                  front_reg;
    logic                   m_tvalid_reg;
    logic [M_DATA_W-1:0]    m_tdata_reg, m_tdata_next;

    store_req_t             store_req;
    word_t                  rd_data;
    slot_t                  src_slot;
    logic                   out_load;

    // decision signals
    logic [CMP_W-1:0]       n_ext, pos_ext, p_sel;
    logic                   is_ins, is_era, go_front;
    slot_t                  p_slot, h_dec;

    ide_store u_store (
        .aclk    (aclk),
        .req     (store_req),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_CAP_B) && (!m_tvalid_reg || m_tready);

    // source slot of the current move, one step from the destination
    assign src_slot = up_reg ? slot_inc(dst_reg) : slot_dec(dst_reg);

    // request classification, status and shift plan
    always_comb begin
        n_ext   = CMP_W'(count_reg);
        pos_ext = CMP_W'(pos_reg);
        is_ins  = 1'b0;
        is_era  = 1'b0;
        p_sel   = '0;
        status_next = ST_DONE;
        case (req_reg)
            REQ_PUSH_FRONT: begin
                is_ins = 1'b1;
                p_sel  = '0;
                if (count_reg >= CNT_W'(DEPTH)) status_next = ST_FULL;
            end
            REQ_PUSH_BACK: begin
                is_ins = 1'b1;
                p_sel  = n_ext;
                if (count_reg >= CNT_W'(DEPTH)) status_next = ST_FULL;
            end
            REQ_POP_FRONT: begin
                is_era = 1'b1;
                p_sel  = '0;
                if (count_reg == '0) status_next = ST_EMPTY;
            end
            REQ_POP_BACK: begin
                is_era = 1'b1;
                p_sel  = n_ext - CMP_W'(1);
                if (count_reg == '0) status_next = ST_EMPTY;
            end
            REQ_INSERT: begin
                is_ins = 1'b1;
                p_sel  = pos_ext;
                if (pos_ext > n_ext) status_next = ST_BAD_POS;
                else if (count_reg >= CNT_W'(DEPTH)) status_next = ST_FULL;
            end
            REQ_ERASE: begin
                is_era = 1'b1;
                p_sel  = pos_ext;
                if (pos_ext >= n_ext) status_next = ST_BAD_POS;
            end
            default: begin
                status_next = ST_DONE;
            end
        endcase
        p_slot   = p_sel[ADDR_W-1:0];
        h_dec    = slot_dec(head_reg);
        go_front = is_ins ? ((p_sel << 1) < n_ext)
                          : (((p_sel << 1) + CMP_W'(1)) < n_ext);
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        dst_next   = dst_reg;
        up_next    = up_reg;
        steps_next = steps_reg;
        put_next   = put_reg;
        ins_next   = ins_reg;
        store_req  = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                ins_next   = 1'b0;
                steps_next = '0;
                if (status_next == ST_DONE && is_ins) begin
                    ins_next   = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (go_front) begin
                        head_next  = h_dec;
                        dst_next   = h_dec;
                        up_next    = 1'b1;
                        steps_next = p_sel[CNT_W-1:0];
                        put_next   = slot_add(h_dec, p_slot);
                    end else begin
                        dst_next   = slot_add(head_reg, count_reg[ADDR_W-1:0]);
                        up_next    = 1'b0;
                        steps_next = count_reg - p_sel[CNT_W-1:0];
                        put_next   = slot_add(head_reg, p_slot);
                    end
                end else if (status_next == ST_DONE && is_era) begin
                    count_next = count_reg - CNT_W'(1);
                    dst_next   = slot_add(head_reg, p_slot);
                    if (go_front) begin
                        head_next  = slot_inc(head_reg);
                        up_next    = 1'b0;
                        steps_next = p_sel[CNT_W-1:0];
                    end else begin
                        up_next    = 1'b1;
                        steps_next = count_reg - CNT_W'(1) - p_sel[CNT_W-1:0];
                    end
                end
                if (status_next == ST_DONE && (is_ins || is_era)
                    && steps_next != '0) begin
                    state_next = S_SHIFT_RD;
                end else if (status_next == ST_DONE && is_ins) begin
                    state_next = S_PUT;
                end else begin
                    state_next = S_FETCH_F;
                end
            end
            S_SHIFT_RD: begin
                store_req.rd_en   = 1'b1;
                store_req.rd_addr = src_slot;
                state_next        = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                store_req.wr_en   = 1'b1;
                store_req.wr_addr = dst_reg;
                store_req.wr_data = rd_data;
                dst_next          = src_slot;
                steps_next        = steps_reg - CNT_W'(1);
                if (steps_reg != CNT_W'(1)) state_next = S_SHIFT_RD;
                else if (ins_reg)           state_next = S_PUT;
                else                        state_next = S_FETCH_F;
            end
            S_PUT: begin
                store_req.wr_en   = 1'b1;
                store_req.wr_addr = put_reg;
                store_req.wr_data = data_reg;
                state_next        = S_FETCH_F;
            end
            S_FETCH_F: begin
                store_req.rd_en   = 1'b1;
                store_req.rd_addr = head_reg;
                state_next        = S_FETCH_B;
            end
            S_FETCH_B: begin
                store_req.rd_en   = 1'b1;
                store_req.rd_addr = slot_add(head_reg,
                                             count_reg[ADDR_W-1:0] - ADDR_W'(1));
                state_next        = S_CAP_B;
            end
            S_CAP_B: begin
                if (out_load) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (out_load)      m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // request capture and working registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg  <= req_t'(s_tuser);
            data_reg <= s_tdata[WORD_BITS-1:0];
            pos_reg  <= s_tdata[WORD_BITS +: POS_W];
        end
        if (state_reg == S_DECIDE) status_reg <= status_next;
        if (state_reg == S_FETCH_B) front_reg <= rd_data;
        dst_reg   <= dst_next;
        up_reg    <= up_next;
        steps_reg <= steps_next;
        put_reg   <= put_next;
        ins_reg   <= ins_next;
    end

    // result packing, words left at zero when the deque is empty
    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[STATUS_W-1:0]      = status_reg;
        m_tdata_next[STATUS_W +: CNT_W] = count_reg;
        if (count_reg != '0) begin
            m_tdata_next[STATUS_W + CNT_W +: WORD_BITS]             = front_reg;
            m_tdata_next[STATUS_W + CNT_W + WORD_BITS +: WORD_BITS] = rd_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
